// ===== hdl/scct_pkg.sv =====
// shared constants and types for the segment and circle collision tester
`default_nettype none
package scct_pkg;
	localparam int COORD_WIDTH = 24;
	localparam int FRAC_BITS   = 8;
	localparam int SQRT_GUARD  = 16;
	localparam int TOL_WIDTH   = 16;

	typedef enum logic [1:0] {
		CMD_CIRCLE     = 2'd0,
		CMD_POINT_SEG  = 2'd1,
		CMD_SEG_CIRCLE = 2'd2,
		CMD_UNUSED     = 2'd3
	} cmd_t;

	// side data travelling alongside the square root lanes
	typedef struct packed {
		cmd_t cmd;
		logic cc_hit;
	} side_t;
endpackage
`default_nettype wire

// ===== hdl/segment_circle_collision_test_unit.sv =====
// top level of the pipelined segment and circle collision tester
`default_nettype none
// Collision tester for circles, points and segments in signed fixed point.
// One query may be transferred every cycle; the pipeline depth is set by the
// bit-per-stage square root that serves the point-on-segment test, which every command
// travels through so results leave in order. A stall at the output freezes the whole
// pipeline. The user must write segment_tolerance through cfg_we/cfg_wdata only while
// no query is in flight; the block itself does not enforce this.
module segment_circle_collision_test_unit #(
	parameter int COORD_WIDTH = scct_pkg::COORD_WIDTH,
	parameter int FRAC_BITS   = scct_pkg::FRAC_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [scct_pkg::TOL_WIDTH-1:0]   cfg_wdata,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       command,
	input  wire logic signed [COORD_WIDTH-1:0]    ax,
	input  wire logic signed [COORD_WIDTH-1:0]    ay,
	input  wire logic signed [COORD_WIDTH-1:0]    bx,
	input  wire logic signed [COORD_WIDTH-1:0]    by,
	input  wire logic signed [COORD_WIDTH-1:0]    cx,
	input  wire logic signed [COORD_WIDTH-1:0]    cy,
	input  wire logic [COORD_WIDTH-2:0]           radius_a,
	input  wire logic [COORD_WIDTH-2:0]           radius_c,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  hit
);
	import scct_pkg::*;

	localparam int W       = COORD_WIDTH;
	localparam int D       = W + 1;
	localparam int PW      = 4 * D;
	localparam int R       = (2*D + 2*SQRT_GUARD + 1) / 2;
	localparam int SW      = ((R > TOL_WIDTH + SQRT_GUARD) ? R : TOL_WIDTH + SQRT_GUARD) + 1;
	localparam int TolReset = ((1 << FRAC_BITS) + 5) / 10;
	localparam int SideDepth = R - 1;
	localparam int ScDepth   = R - 4;

	logic adv;
	logic [TOL_WIDTH-1:0] tol_q;

	assign adv      = !out_valid | out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_WIDTH'(TolReset);
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// stage 1: differences
	logic v_s1, v_s2, v_s3, v_s4;
	cmd_t cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic signed [D-1:0] ex_s1, ey_s1, fx_s1, fy_s1, dbx_s1, dby_s1;
	logic [W-1:0]   rsum_s1;
	logic [W-2:0]   rc_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= cmd_t'(command);
			ex_s1   <= D'(bx) - D'(ax);
			ey_s1   <= D'(by) - D'(ay);
			fx_s1   <= D'(cx) - D'(ax);
			fy_s1   <= D'(cy) - D'(ay);
			dbx_s1  <= D'(bx) - D'(cx);
			dby_s1  <= D'(by) - D'(cy);
			rsum_s1 <= W'(radius_a) + W'(radius_c);
			rc_s1   <= radius_c;
		end
	end

	// stage 2: products
	logic signed [2*D-1:0] fx2_s2, fy2_s2, bx2_s2, by2_s2, ex2_s2, ey2_s2;
	logic signed [2*D-1:0] fxex_s2, fyey_s2, fxey_s2, fyex_s2;
	logic [2*W-1:0] rs2_s2;
	logic [2*W-3:0] rc2_s2;
	logic zero_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2  <= cmd_s1;
			fx2_s2  <= fx_s1 * fx_s1;
			fy2_s2  <= fy_s1 * fy_s1;
			bx2_s2  <= dbx_s1 * dbx_s1;
			by2_s2  <= dby_s1 * dby_s1;
			ex2_s2  <= ex_s1 * ex_s1;
			ey2_s2  <= ey_s1 * ey_s1;
			fxex_s2 <= fx_s1 * ex_s1;
			fyey_s2 <= fy_s1 * ey_s1;
			fxey_s2 <= fx_s1 * ey_s1;
			fyex_s2 <= fy_s1 * ex_s1;
			rs2_s2  <= rsum_s1 * rsum_s1;
			rc2_s2  <= rc_s1 * rc_s1;
			zero_s2 <= (ex_s1 == '0) && (ey_s1 == '0);
		end
	end

	// stage 3: sums
	logic [2*D-1:0] da2_s3, db2_s3, len2_s3;
	logic signed [2*D-1:0] dot_s3, cross_s3;
	logic [2*W-1:0] rs2_s3;
	logic [2*W-3:0] rc2_s3;
	logic zero_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s3   <= cmd_s2;
			da2_s3   <= $unsigned(fx2_s2 + fy2_s2);
			db2_s3   <= $unsigned(bx2_s2 + by2_s2);
			len2_s3  <= $unsigned(ex2_s2 + ey2_s2);
			dot_s3   <= fxex_s2 + fyey_s2;
			cross_s3 <= fxey_s2 - fyex_s2;
			rs2_s3   <= rs2_s2;
			rc2_s3   <= rc2_s2;
			zero_s3  <= zero_s2;
		end
	end

	// stage 4: compares and cross magnitude
	logic [2*D-1:0] cneg;
	logic [2*D-2:0] cabs_s4;
	logic [2*D-1:0] len2_s4;
	logic [2*W-3:0] rc2_s4;
	logic cc_s4, ep_s4, dok_s4, zero_s4;

	assign cneg = cross_s3[2*D-1] ? $unsigned(-cross_s3) : $unsigned(cross_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s4  <= cmd_s3;
			cabs_s4 <= cneg[2*D-2:0];
			len2_s4 <= len2_s3;
			rc2_s4  <= rc2_s3;
			cc_s4   <= da2_s3 <= (2*D)'(rs2_s3);
			ep_s4   <= (da2_s3 <= (2*D)'(rc2_s3)) || (db2_s3 <= (2*D)'(rc2_s3));
			dok_s4  <= !dot_s3[2*D-1] && ($unsigned(dot_s3) <= len2_s3);
			zero_s4 <= zero_s3;
		end
	end

	// stage 5: partial products of cross^2 and rc^2 * len^2
	logic [D-2:0]   ca_hi, ln_hi;
	logic [D-1:0]   ca_lo, ln_lo, rc_lo;
	logic [W-4:0]   rc_hi;
	logic [2*D-1:0] chh_s5, chl_s5, cll_s5, rhh_s5, rhl_s5, rlh_s5, rll_s5;
	logic ep_s5, dok_s5, zero_s5;

	assign ca_hi = cabs_s4[2*D-2:D];
	assign ca_lo = cabs_s4[D-1:0];
	assign ln_hi = len2_s4[2*D-2:D];
	assign ln_lo = len2_s4[D-1:0];
	assign rc_hi = rc2_s4[2*W-3:D];
	assign rc_lo = rc2_s4[D-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			chh_s5  <= ca_hi * ca_hi;
			chl_s5  <= ca_hi * ca_lo;
			cll_s5  <= ca_lo * ca_lo;
			rhh_s5  <= rc_hi * ln_hi;
			rhl_s5  <= rc_hi * ln_lo;
			rlh_s5  <= rc_lo * ln_hi;
			rll_s5  <= rc_lo * ln_lo;
			ep_s5   <= ep_s4;
			dok_s5  <= dok_s4;
			zero_s5 <= zero_s4;
		end
	end

	// stage 6: recombine partial products
	logic [PW-1:0] cross2_s6, rl2_s6;
	logic ep_s6, dok_s6, zero_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			cross2_s6 <= (PW'(chh_s5) << (2*D)) + (PW'(chl_s5) << (D+1)) + PW'(cll_s5);
			rl2_s6    <= (PW'(rhh_s5) << (2*D)) + ((PW'(rhl_s5) + PW'(rlh_s5)) << D)
				+ PW'(rll_s5);
			ep_s6     <= ep_s5;
			dok_s6    <= dok_s5;
			zero_s6   <= zero_s5;
		end
	end

	// stage 7: segment against circle verdict
	logic sc_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s7  <= ep_s6 || (!zero_s6 && dok_s6 && (cross2_s6 <= rl2_s6));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// distances for the point-on-segment test
	logic [R-1:0] d1, d2, dlen;

	scct_isqrt_pipe #(.IN_W(2*D), .GUARD(SQRT_GUARD)) u_sqrt_a (
		.clk(clk), .en(adv), .n(da2_s3), .root(d1)
	);
	scct_isqrt_pipe #(.IN_W(2*D), .GUARD(SQRT_GUARD)) u_sqrt_b (
		.clk(clk), .en(adv), .n(db2_s3), .root(d2)
	);
	scct_isqrt_pipe #(.IN_W(2*D), .GUARD(SQRT_GUARD)) u_sqrt_len (
		.clk(clk), .en(adv), .n(len2_s3), .root(dlen)
	);

	// delay lines matching the square root latency
	side_t side_sd [SideDepth];
	logic  vld_sd  [SideDepth];
	logic  sc_sd   [ScDepth];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sd[0] <= '{cmd: cmd_s4, cc_hit: cc_s4};
			for (int k = 1; k < SideDepth; k++) begin
				side_sd[k] <= side_sd[k-1];
			end
			sc_sd[0] <= sc_s7;
			for (int k = 1; k < ScDepth; k++) begin
				sc_sd[k] <= sc_sd[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SideDepth; k++) begin
				vld_sd[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_sd[0] <= v_s4;
			for (int k = 1; k < SideDepth; k++) begin
				vld_sd[k] <= vld_sd[k-1];
			end
		end
	end

	// final verdict into the output register
	logic [SW-1:0] dsum, dlim;
	logic          res;
	side_t         side_end;

	assign side_end = side_sd[SideDepth-1];
	assign dsum     = SW'(d1) + SW'(d2);
	assign dlim     = SW'(dlen) + (SW'(tol_q) << SQRT_GUARD);

	always_comb begin
		case (side_end.cmd)
			CMD_CIRCLE:     res = side_end.cc_hit;
			CMD_POINT_SEG:  res = dsum <= dlim;
			CMD_SEG_CIRCLE: res = sc_sd[ScDepth-1];
			default:        res = 1'b0;
		endcase
	end

	logic out_valid_q, hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_sd[SideDepth-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
endmodule
`default_nettype wire

// ===== hdl/scct_isqrt_pipe.sv =====
// pipelined integer square root, one result bit per stage, input scaled by 2^(2*guard)
`default_nettype none
module scct_isqrt_pipe #(
	parameter int IN_W  = 50,
	parameter int GUARD = scct_pkg::SQRT_GUARD
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [IN_W-1:0]               n,
	output logic      [(IN_W+2*GUARD+1)/2-1:0] root
);
	import scct_pkg::*;

	localparam int R  = (IN_W + 2*GUARD + 1) / 2;
	localparam int XW = 2 * R;

	logic [R+1:0] rem_sn  [R];
	logic [R-1:0] root_sn [R];
	logic [XW-1:0] x_sn   [R];

	for (genvar k = 0; k < R; k++) begin : g_stage
		logic [R+1:0]  rem_p;
		logic [R-1:0]  root_p;
		logic [XW-1:0] x_p;
		logic [R+1:0]  remsh;
		logic [R+1:0]  trial;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign x_p    = XW'(n) << (2*GUARD);
		end else begin : g_next
			assign rem_p  = rem_sn[k-1];
			assign root_p = root_sn[k-1];
			assign x_p    = x_sn[k-1];
		end

		assign remsh = {rem_p[R-1:0], x_p[XW-1 -: 2]};
		assign trial = {root_p, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				x_sn[k] <= x_p << 2;
				if (remsh >= trial) begin
					rem_sn[k]  <= remsh - trial;
					root_sn[k] <= {root_p[R-2:0], 1'b1};
				end else begin
					rem_sn[k]  <= remsh;
					root_sn[k] <= {root_p[R-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_sn[R-1];
endmodule
`default_nettype wire
